// ----- rtl/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants for the banked register file
// Mode codes, status bit positions, bank lookup functions, the opcode and
// state enums, and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned MODE_W   = 5;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned NUM_REGS = 16;
    localparam int unsigned BANK_W   = 3;
    localparam int unsigned NUM_BANKS = 6;
    localparam int unsigned NUM_HIGH = 5;   // R8..R12 banked for FIQ
    localparam int unsigned HIGH_BASE = 8;
    localparam int unsigned NUM_SAVED = 5;

    // Processor mode codes
    localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
    localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
    localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

    // Status word layout
    localparam int unsigned THUMB_BIT = 5;
    localparam int unsigned IRQ_MASK_BIT = 7;
    localparam logic [WORD_W-1:0] STATUS_RESET   = 32'h0000_001F;
    localparam logic [WORD_W-1:0] STATUS_LOW_CLR = 32'h0000_003F;
    localparam logic [WORD_W-1:0] STATUS_IRQ_SET = 32'h0000_0092;

    // Program counter and link offsets as seen in R15, and the IRQ vector
    localparam logic [WORD_W-1:0] PC_OFS_ARM   = 32'd8;
    localparam logic [WORD_W-1:0] PC_OFS_THUMB = 32'd4;
    localparam logic [WORD_W-1:0] LINK_OFS_ARM = 32'd4;
    localparam logic [WORD_W-1:0] IRQ_VECTOR   = 32'hFFFF_0018;

    // Register numbers with a fixed role
    localparam logic [IDX_W-1:0] REG_SP = 4'd13;
    localparam logic [IDX_W-1:0] REG_LR = 4'd14;
    localparam logic [IDX_W-1:0] REG_PC = 4'd15;

    // Saved-status slots
    localparam logic [BANK_W-1:0] SAVED_FIQ  = 3'd0;
    localparam logic [BANK_W-1:0] SAVED_SVC  = 3'd1;
    localparam logic [BANK_W-1:0] SAVED_ABT  = 3'd2;
    localparam logic [BANK_W-1:0] SAVED_IRQ  = 3'd3;
    localparam logic [BANK_W-1:0] SAVED_UND  = 3'd4;
    localparam logic [BANK_W-1:0] SAVED_NONE = 3'd5;

    // SP/LR bank slots
    localparam logic [BANK_W-1:0] BANK_USR = 3'd0;
    localparam logic [BANK_W-1:0] BANK_FIQ = 3'd1;
    localparam logic [BANK_W-1:0] BANK_IRQ = 3'd2;
    localparam logic [BANK_W-1:0] BANK_SVC = 3'd3;
    localparam logic [BANK_W-1:0] BANK_ABT = 3'd4;
    localparam logic [BANK_W-1:0] BANK_UND = 3'd5;

    typedef enum logic [2:0] {
        OP_READ_REG    = 3'd0,
        OP_WRITE_REG   = 3'd1,
        OP_WRITE_STAT  = 3'd2,
        OP_READ_SAVED  = 3'd3,
        OP_WRITE_SAVED = 3'd4,
        OP_IRQ         = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SAVE,
        ST_LOAD,
        ST_LINK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic bank_save;
        logic bank_load;
        logic irq_link;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic swap_needed;
        logic irq_go;
        logic taken;
    } t_dp_sts;

    // SP/LR bank of a mode; unknown modes share the user bank
    function automatic logic [BANK_W-1:0] bank_of(input logic [MODE_W-1:0] mode);
        logic [BANK_W-1:0] b;
        case (mode)
            MODE_FIQ: b = BANK_FIQ;
            MODE_IRQ: b = BANK_IRQ;
            MODE_SVC: b = BANK_SVC;
            MODE_ABT: b = BANK_ABT;
            MODE_UND: b = BANK_UND;
            default:  b = BANK_USR;
        endcase
        return b;
    endfunction

    // Saved-status slot of a mode, SAVED_NONE where the mode has none
    function automatic logic [BANK_W-1:0] saved_of(input logic [MODE_W-1:0] mode);
        logic [BANK_W-1:0] s;
        case (mode)
            MODE_FIQ: s = SAVED_FIQ;
            MODE_SVC: s = SAVED_SVC;
            MODE_ABT: s = SAVED_ABT;
            MODE_IRQ: s = SAVED_IRQ;
            MODE_UND: s = SAVED_UND;
            default:  s = SAVED_NONE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/brf_ctrl.sv -----
// ----------------------------------------------------------------------------
// brf_ctrl: sequencer for the banked register file
// Steps one word through execute, bank save, bank load and IRQ link, and
// owns the handshakes and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ctrl
    import brf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output logic         o_cfg_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.swap_needed) begin
                    n_state = ST_SAVE;
                end else if (i_sts.irq_go) begin
                    n_state = ST_LINK;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SAVE: n_state = ST_LOAD;
            ST_LOAD: begin
                n_state = i_sts.taken ? ST_LINK : ST_FINISH;
            end
            ST_LINK: n_state = ST_FINISH;
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands and handshakes
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cfg_ready     = 1'b1;
                o_cmd.latch_in  = i_in_valid;
            end
            ST_EXEC:   o_cmd.exec      = 1'b1;
            ST_SAVE:   o_cmd.bank_save = 1'b1;
            ST_LOAD:   o_cmd.bank_load = 1'b1;
            ST_LINK:   o_cmd.irq_link  = 1'b1;
            ST_FINISH: o_cmd.load_out  = !r_out_valid || i_out_ready;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/brf_datapath.sv -----
// ----------------------------------------------------------------------------
// brf_datapath: register storage and moves of the banked register file
// Holds the visible registers, status, SP/LR banks, R8-R12 banks and saved
// status, and performs each step as commanded by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_datapath
    import brf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic [WORD_W-1:0] i_cfg_data,
    input  wire logic [2:0]        i_opcode,
    input  wire logic [IDX_W-1:0]  i_reg_index,
    input  wire logic [WORD_W-1:0] i_write_value,
    output logic [WORD_W-1:0]      o_read_data,
    output logic                   o_irq_taken,
    output logic [WORD_W-1:0]      o_status_word
);

    // Architectural state
    logic [WORD_W-1:0] r_vis    [NUM_REGS];
    logic [WORD_W-1:0] r_bank_sp [NUM_BANKS];
    logic [WORD_W-1:0] r_bank_lr [NUM_BANKS];
    logic [WORD_W-1:0] r_fiq_hi [NUM_HIGH];
    logic [WORD_W-1:0] r_usr_hi [NUM_HIGH];
    logic [WORD_W-1:0] r_saved  [NUM_SAVED];
    logic [WORD_W-1:0] r_status;

    // Word in flight
    logic [2:0]        r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_wval;
    logic [WORD_W-1:0] r_rd;
    logic              r_taken;
    logic [WORD_W-1:0] r_old_status;
    logic [MODE_W-1:0] r_old_mode;

    // Result register
    logic [WORD_W-1:0] r_out_rd;
    logic              r_out_taken;
    logic [WORD_W-1:0] r_out_status;

    logic [MODE_W-1:0] cur_mode;
    logic [MODE_W-1:0] new_mode;
    logic              mode_change;
    logic              usr_sys_pair;
    logic [BANK_W-1:0] saved_sel;
    logic [WORD_W-1:0] rd_next;
    logic [WORD_W-1:0] wr_val;
    logic [BANK_W-1:0] old_bank;
    logic [BANK_W-1:0] new_bank;

    assign cur_mode = r_status[MODE_W-1:0];
    assign saved_sel = saved_of(cur_mode);
    assign old_bank = bank_of(r_old_mode);
    assign new_bank = bank_of(cur_mode);

    // Mode the current op switches to, and whether banks move
    always_comb begin
        o_sts.irq_go = (r_op == OP_IRQ) && !r_status[IRQ_MASK_BIT];
        new_mode     = (r_op == OP_WRITE_STAT) ? r_wval[MODE_W-1:0] : MODE_IRQ;
        mode_change  = (r_op == OP_WRITE_STAT) || o_sts.irq_go;
        usr_sys_pair = ((cur_mode == MODE_USR) && (new_mode == MODE_SYS)) ||
                       ((cur_mode == MODE_SYS) && (new_mode == MODE_USR));
        o_sts.swap_needed = mode_change && (cur_mode != new_mode) && !usr_sys_pair;
        o_sts.taken       = r_taken;
    end

    // Read result of the op
    always_comb begin
        rd_next = '0;
        case (r_op)
            OP_READ_REG: rd_next = r_vis[r_idx];
            OP_READ_SAVED: begin
                if (saved_sel == SAVED_NONE) begin
                    rd_next = r_status;
                end else begin
                    rd_next = r_saved[saved_sel];
                end
            end
            default: rd_next = '0;
        endcase
    end

    // R15 writes carry the pipeline offset
    always_comb begin
        wr_val = r_wval;
        if (r_idx == REG_PC) begin
            wr_val = r_wval + (r_status[THUMB_BIT] ? PC_OFS_THUMB : PC_OFS_ARM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS - 1; i++) begin
                r_vis[i] <= '0;
            end
            r_vis[REG_PC] <= PC_OFS_ARM;
            for (int i = 0; i < NUM_BANKS; i++) begin
                r_bank_sp[i] <= '0;
                r_bank_lr[i] <= '0;
            end
            for (int i = 0; i < NUM_HIGH; i++) begin
                r_fiq_hi[i] <= '0;
                r_usr_hi[i] <= '0;
            end
            for (int i = 0; i < NUM_SAVED; i++) begin
                r_saved[i] <= '0;
            end
            r_status <= STATUS_RESET;
            r_taken  <= 1'b0;
        end else begin
            // Boot address write reloads the program counter
            if (i_cfg_we) begin
                r_vis[REG_PC] <= i_cfg_data + PC_OFS_ARM;
            end

            // Capture the incoming word
            if (i_cmd.latch_in) begin
                r_op   <= i_opcode;
                r_idx  <= i_reg_index;
                r_wval <= i_write_value;
            end

            // Execute step of the op
            if (i_cmd.exec) begin
                r_rd       <= rd_next;
                r_taken    <= o_sts.irq_go;
                r_old_mode <= cur_mode;
                case (r_op)
                    OP_WRITE_REG: r_vis[r_idx] <= wr_val;
                    OP_WRITE_STAT: r_status <= r_wval;
                    OP_WRITE_SAVED: begin
                        if (saved_sel != SAVED_NONE) begin
                            r_saved[saved_sel] <= r_wval;
                        end
                    end
                    OP_IRQ: begin
                        if (o_sts.irq_go) begin
                            r_old_status       <= r_status;
                            r_status           <= (r_status & ~STATUS_LOW_CLR) | STATUS_IRQ_SET;
                            r_saved[SAVED_IRQ] <= r_status;
                        end
                    end
                    default: ;
                endcase
            end

            // Bank out the registers of the old mode
            if (i_cmd.bank_save) begin
                if (r_old_mode == MODE_FIQ) begin
                    for (int i = 0; i < NUM_HIGH; i++) begin
                        r_fiq_hi[i]           <= r_vis[HIGH_BASE + i];
                        r_vis[HIGH_BASE + i]  <= r_usr_hi[i];
                    end
                end
                r_bank_sp[old_bank] <= r_vis[REG_SP];
                r_bank_lr[old_bank] <= r_vis[REG_LR];
            end

            // Bank in the registers of the new mode
            if (i_cmd.bank_load) begin
                if (cur_mode == MODE_FIQ) begin
                    for (int i = 0; i < NUM_HIGH; i++) begin
                        r_usr_hi[i]           <= r_vis[HIGH_BASE + i];
                        r_vis[HIGH_BASE + i]  <= r_fiq_hi[i];
                    end
                end
                r_vis[REG_SP] <= r_bank_sp[new_bank];
                r_vis[REG_LR] <= r_bank_lr[new_bank];
            end

            // Set return address and jump to the IRQ vector
            if (i_cmd.irq_link) begin
                r_vis[REG_LR] <= r_vis[REG_PC] -
                                 (r_old_status[THUMB_BIT] ? '0 : LINK_OFS_ARM);
                r_vis[REG_PC] <= IRQ_VECTOR + PC_OFS_ARM;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rd     <= r_rd;
            r_out_taken  <= r_taken;
            r_out_status <= r_status;
        end
    end

    assign o_read_data   = r_out_rd;
    assign o_irq_taken   = r_out_taken;
    assign o_status_word = r_out_status;

endmodule

`default_nettype wire

// ----- rtl/banked_register_file_core.sv -----
// The controller sequences each word one at a time: execute, then bank save
// and bank load on a mode change that swaps banks, then link for a taken IRQ,
// then a finish step that loads the result register and holds while the
// previous result waits. A new word is accepted only in idle, after the last
// word has finished. Reset (synchronous, active low): registers zero,
// R15 = 8, status 0x1F.
// ----------------------------------------------------------------------------
// banked_register_file_core: mode-banked register file
// Reads and writes visible registers, status and saved status, swaps
// SP/LR and R8-R12 banks on mode changes, and takes interrupt requests.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_register_file_core
    import brf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [2:0]        i_opcode,
    input  wire logic [IDX_W-1:0]  i_reg_index,
    input  wire logic [WORD_W-1:0] i_write_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [WORD_W-1:0]      o_read_data,
    output logic                   o_irq_taken,
    output logic [WORD_W-1:0]      o_status_word,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [WORD_W-1:0] i_cfg_entry_address
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_we;

    assign cfg_we = i_cfg_valid && o_cfg_ready;

    // Sequencer
    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Storage and moves
    brf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (i_cfg_entry_address),
        .i_opcode      (i_opcode),
        .i_reg_index   (i_reg_index),
        .i_write_value (i_write_value),
        .o_read_data   (o_read_data),
        .o_irq_taken   (o_irq_taken),
        .o_status_word (o_status_word)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_banked_register_file_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_banked_register_file_core: self-checking bench for the banked register file
// Drives register, status, saved-status and interrupt words through the
// valid/ready ports and predicts every result with a cycle-free shadow of the
// register file, its SP/LR and R8-R12 banks and the saved status slots.
// Directed corner words come first, then bursty random traffic with receiver
// stalls, a long output hold-off and entry-address rewrites between phases.
// ----------------------------------------------------------------------------

import brf_pkg::*;

typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq_taken;
    logic [WORD_W-1:0] status_word;
} t_brf_result;

typedef struct packed {
    logic [2:0]        opcode;
    logic [IDX_W-1:0]  reg_index;
    logic [WORD_W-1:0] write_value;
} t_brf_word;

class bank_file_scoreboard;
    logic [WORD_W-1:0] gpr [NUM_REGS];
    logic [WORD_W-1:0] status;
    logic [MODE_W-1:0] prev_mode;
    logic [WORD_W-1:0] sp_lr [2*NUM_BANKS];
    logic [WORD_W-1:0] fiq_high [NUM_HIGH];
    logic [WORD_W-1:0] usr_high [NUM_HIGH];
    logic [WORD_W-1:0] saved [NUM_SAVED];
    t_brf_result       due_results [$];
    int errors;
    int checked;
    int irqs_taken;
    int bank_swaps;
    int entry_writes;

    function new();
        foreach (gpr[i]) gpr[i] = '0;
        foreach (sp_lr[i]) sp_lr[i] = '0;
        foreach (fiq_high[i]) fiq_high[i] = '0;
        foreach (usr_high[i]) usr_high[i] = '0;
        foreach (saved[i]) saved[i] = '0;
        gpr[REG_PC] = PC_OFS_ARM;
        status = STATUS_RESET;
        prev_mode = MODE_SYS;
        errors = 0;
        checked = 0;
        irqs_taken = 0;
        bank_swaps = 0;
        entry_writes = 0;
    endfunction

    // SP/LR pair of a mode; anything unknown lands in the user pair
    function logic [BANK_W-1:0] mode_bank(logic [MODE_W-1:0] mode);
        case (mode)
            MODE_FIQ: return BANK_FIQ;
            MODE_IRQ: return BANK_IRQ;
            MODE_SVC: return BANK_SVC;
            MODE_ABT: return BANK_ABT;
            MODE_UND: return BANK_UND;
            default:  return BANK_USR;
        endcase
    endfunction

    function logic [BANK_W-1:0] mode_saved_slot(logic [MODE_W-1:0] mode);
        case (mode)
            MODE_FIQ: return SAVED_FIQ;
            MODE_SVC: return SAVED_SVC;
            MODE_ABT: return SAVED_ABT;
            MODE_IRQ: return SAVED_IRQ;
            MODE_UND: return SAVED_UND;
            default:  return SAVED_NONE;
        endcase
    endfunction

    // Move banked registers out for the old mode and in for the new one
    function void switch_banks();
        logic [MODE_W-1:0] from_mode;
        logic [MODE_W-1:0] to_mode;
        logic [BANK_W-1:0] b;
        from_mode = prev_mode;
        to_mode = status[MODE_W-1:0];
        prev_mode = to_mode;
        if (from_mode == to_mode) return;
        if ((from_mode == MODE_USR && to_mode == MODE_SYS) ||
            (from_mode == MODE_SYS && to_mode == MODE_USR)) return;
        bank_swaps++;
        if (from_mode == MODE_FIQ) begin
            for (int i = 0; i < NUM_HIGH; i++) begin
                fiq_high[i] = gpr[HIGH_BASE + i];
                gpr[HIGH_BASE + i] = usr_high[i];
            end
        end
        b = mode_bank(from_mode);
        sp_lr[2*b] = gpr[REG_SP];
        sp_lr[2*b + 1] = gpr[REG_LR];
        if (to_mode == MODE_FIQ) begin
            for (int i = 0; i < NUM_HIGH; i++) begin
                usr_high[i] = gpr[HIGH_BASE + i];
                gpr[HIGH_BASE + i] = fiq_high[i];
            end
        end
        b = mode_bank(to_mode);
        gpr[REG_SP] = sp_lr[2*b];
        gpr[REG_LR] = sp_lr[2*b + 1];
    endfunction

    // R15 writes carry the pipeline offset of the current state
    function void put_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] value);
        if (idx == REG_PC)
            value = value + (status[THUMB_BIT] ? PC_OFS_THUMB : PC_OFS_ARM);
        gpr[idx] = value;
    endfunction

    function void load_entry(logic [WORD_W-1:0] addr);
        gpr[REG_PC] = addr + PC_OFS_ARM;
        entry_writes++;
    endfunction

    // Apply one accepted word and queue the result it must produce
    function void note_word(logic [2:0] op, logic [IDX_W-1:0] idx,
                            logic [WORD_W-1:0] val);
        t_brf_result r;
        logic [WORD_W-1:0] old_status;
        logic [WORD_W-1:0] link_ofs;
        logic [BANK_W-1:0] s;
        r = '0;
        s = mode_saved_slot(status[MODE_W-1:0]);
        case (op)
            OP_READ_REG:   r.read_data = gpr[idx];
            OP_WRITE_REG:  put_reg(idx, val);
            OP_WRITE_STAT: begin
                status = val;
                switch_banks();
            end
            OP_READ_SAVED: r.read_data = (s == SAVED_NONE) ? status : saved[s];
            OP_WRITE_SAVED: begin
                if (s != SAVED_NONE) saved[s] = val;
            end
            OP_IRQ: begin
                if (!status[IRQ_MASK_BIT]) begin
                    old_status = status;
                    link_ofs = old_status[THUMB_BIT] ? '0 : LINK_OFS_ARM;
                    status = (status & ~STATUS_LOW_CLR) | STATUS_IRQ_SET;
                    switch_banks();
                    saved[SAVED_IRQ] = old_status;
                    gpr[REG_LR] = gpr[REG_PC] - link_ofs;
                    put_reg(REG_PC, IRQ_VECTOR);
                    r.irq_taken = 1'b1;
                    irqs_taken++;
                end
            end
            default: ;
        endcase
        r.status_word = status;
        due_results.push_back(r);
    endfunction

    function void field_check(string name, logic [WORD_W-1:0] exp_v,
                              logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Compare one delivered result with the oldest queued one
    function void check_word(logic [WORD_W-1:0] rd, logic taken, logic [WORD_W-1:0] st);
        t_brf_result e;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result, read_data %h irq_taken %b status_word %h",
                     $time, rd, taken, st);
            errors++;
            return;
        end
        e = due_results.pop_front();
        checked++;
        field_check("read_data", e.read_data, rd);
        field_check("irq_taken", {31'b0, e.irq_taken}, {31'b0, taken});
        field_check("status_word", e.status_word, st);
    endfunction
endclass

module tb_banked_register_file_core;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TIMEOUT_CYCLES = 250000;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [2:0]        i_opcode = '0;
    logic [IDX_W-1:0]  i_reg_index = '0;
    logic [WORD_W-1:0] i_write_value = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [WORD_W-1:0] o_read_data;
    logic              o_irq_taken;
    logic [WORD_W-1:0] o_status_word;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [WORD_W-1:0] i_cfg_entry_address = '0;

    logic hold_request = 1'b0;
    bank_file_scoreboard sb = new();

    banked_register_file_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_reg_index         (i_reg_index),
        .i_write_value       (i_write_value),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_read_data         (o_read_data),
        .o_irq_taken         (o_irq_taken),
        .o_status_word       (o_status_word),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_entry_address (i_cfg_entry_address)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // Watch all three handshakes; results are checked before the new word is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_word(o_read_data, o_irq_taken, o_status_word);
            if (i_cfg_valid && o_cfg_ready)
                sb.load_entry(i_cfg_entry_address);
            if (i_in_valid && o_in_ready)
                sb.note_word(i_opcode, i_reg_index, i_write_value);
        end
    end

    // Receiver: rotate through stall patterns, plus one long hold-off on request
    int  rx_cycle = 0;
    int  rx_mode = 0;
    int  rx_mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(50, 150);
        end else begin
            rx_mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                2:       i_out_ready <= ((rx_cycle % 7) < 3);
                default: i_out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Hard stop if the block hangs
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_banked_register_file_core: done, errors");
        $finish;
    end

    // Offer one word and hold it until accepted; valid stays high afterward
    task automatic send_word(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] val);
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_reg_index <= idx;
        i_write_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic idle(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait for every queued result to come back
    task automatic drain();
        idle(1);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_entry(input logic [WORD_W-1:0] addr);
        i_cfg_valid <= 1'b1;
        i_cfg_entry_address <= addr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] make_status(logic [MODE_W-1:0] mode,
                                                      bit thumb, bit irq_off);
        logic [WORD_W-1:0] v;
        v = '0;
        v[MODE_W-1:0] = mode;
        v[THUMB_BIT] = thumb;
        v[IRQ_MASK_BIT] = irq_off;
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Mostly real modes, some invalid ones, random upper bits
    function automatic logic [WORD_W-1:0] random_status();
        logic [WORD_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 19))
            0, 1, 2:  v[MODE_W-1:0] = MODE_USR;
            3, 4, 5:  v[MODE_W-1:0] = MODE_FIQ;
            6, 7:     v[MODE_W-1:0] = MODE_IRQ;
            8, 9:     v[MODE_W-1:0] = MODE_SVC;
            10, 11:   v[MODE_W-1:0] = MODE_ABT;
            12, 13:   v[MODE_W-1:0] = MODE_UND;
            14, 15, 16: v[MODE_W-1:0] = MODE_SYS;
            default:  v[MODE_W-1:0] = MODE_W'($urandom);
        endcase
        v[THUMB_BIT] = ($urandom_range(0, 3) == 0);
        v[IRQ_MASK_BIT] = ($urandom_range(0, 2) == 0);
        return v;
    endfunction

    function automatic t_brf_word random_word();
        t_brf_word w;
        int pick;
        pick = $urandom_range(0, 99);
        w.reg_index = IDX_W'($urandom_range(0, 15));
        w.write_value = random_value();
        if (pick < 25)      w.opcode = OP_READ_REG;
        else if (pick < 45) w.opcode = OP_WRITE_REG;
        else if (pick < 63) begin
            w.opcode = OP_WRITE_STAT;
            w.write_value = random_status();
        end
        else if (pick < 73) w.opcode = OP_READ_SAVED;
        else if (pick < 83) w.opcode = OP_WRITE_SAVED;
        else if (pick < 97) w.opcode = OP_IRQ;
        else                w.opcode = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
        return w;
    endfunction

    // Random words in bursts; some bursts run long with no gaps at all
    task automatic run_random(input int count);
        t_brf_word w;
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            w = random_word();
            send_word(w.opcode, w.reg_index, w.write_value);
            if (burst > 0) begin
                burst--;
            end else if ($urandom_range(0, 3) == 0) begin
                burst = $urandom_range(20, 60);
            end else begin
                idle($urandom_range(1, 8));
                burst = $urandom_range(0, 12);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners with the reset entry address
        send_word(OP_READ_REG, REG_PC, '0);
        send_word(OP_WRITE_REG, 4'd0, 32'hFFFF_FFFF);
        send_word(OP_READ_REG, 4'd0, '0);
        send_word(OP_WRITE_REG, REG_PC, '0);
        send_word(OP_READ_REG, REG_PC, '0);
        send_word(OP_READ_SAVED, '0, '0);
        send_word(OP_WRITE_SAVED, '0, 32'hDEAD_BEEF);
        send_word(OP_WRITE_STAT, '0, make_status(MODE_FIQ, 1'b0, 1'b0));
        send_word(OP_WRITE_REG, 4'd8, 32'hFFFF_FFFF);
        send_word(OP_WRITE_REG, 4'd12, 32'h0000_0012);
        send_word(OP_WRITE_REG, REG_SP, 32'hAAAA_5555);
        send_word(OP_WRITE_SAVED, '0, 32'h8000_0001);
        send_word(OP_READ_SAVED, '0, '0);
        send_word(OP_WRITE_STAT, '0, make_status(MODE_USR, 1'b0, 1'b0));
        send_word(OP_READ_REG, REG_SP, '0);
        send_word(OP_WRITE_STAT, '0, make_status(MODE_SYS, 1'b0, 1'b0));
        send_word(OP_IRQ, '0, '0);
        send_word(OP_READ_REG, REG_LR, '0);
        send_word(OP_READ_SAVED, '0, '0);
        send_word(OP_IRQ, '0, '0);
        send_word(OP_WRITE_STAT, '0, make_status(MODE_SVC, 1'b1, 1'b0));
        send_word(OP_WRITE_REG, REG_PC, 32'h0000_0100);
        send_word(OP_IRQ, '0, '0);
        send_word(OP_SPARE_LO, 4'hF, 32'hFFFF_FFFF);
        send_word(OP_SPARE_HI, 4'h0, 32'h0000_0000);
        send_word(OP_WRITE_STAT, '0, 32'hFFFF_FF60);
        send_word(OP_WRITE_STAT, '0, 32'hFFFF_FFFF);
        drain();

        // Highest entry address, R15 wraps
        write_entry(32'hFFFF_FFFF);
        send_word(OP_READ_REG, REG_PC, '0);
        run_random(300);
        drain();

        // Lowest entry address, then stall the output while the sender keeps pushing
        write_entry(32'h0000_0000);
        send_word(OP_READ_REG, REG_PC, '0);
        hold_request = 1'b1;
        for (int n = 0; n < 60; n++) begin
            send_word(OP_WRITE_REG, IDX_W'($urandom_range(0, 15)), $urandom);
        end
        drain();

        write_entry($urandom);
        send_word(OP_READ_REG, REG_PC, '0);
        run_random(300);
        drain();

        write_entry(32'h8000_0000);
        run_random(300);
        drain();

        write_entry(32'hFFFF_FFF8);
        send_word(OP_READ_REG, REG_PC, '0);
        run_random(240);
        drain();

        $display("run: %0d results checked, %0d interrupts taken, %0d bank swaps",
                 sb.checked, sb.irqs_taken, sb.bank_swaps);
        $display("run: %0d entry address writes, one long output hold-off",
                 sb.entry_writes);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("tb_banked_register_file_core: done, clean");
        end else begin
            $display("tb_banked_register_file_core: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/brf_pkg.sv
rtl/brf_ctrl.sv
rtl/brf_datapath.sv
rtl/banked_register_file_core.sv
tb/sv/tb_banked_register_file_core.sv
